// ===== hw/rtl/sga_pkg.sv =====
// Shared types and fixed-point constants for the softened gravity accumulator.
`default_nettype none
package sga_pkg;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  shift;
    logic [67:0] rad;
  } arith_req_t;

  localparam logic [5:0]  Q_SHIFT     = 6'd30;
  localparam logic [5:0]  DIR_SHIFT   = 6'd62;
  localparam logic [5:0]  MH_SHIFT    = 6'd32;
  localparam logic [5:0]  MHH_SHIFT   = 6'd16;
  localparam logic [30:0] SOFT_RESET  = 31'd65536;
  localparam logic [63:0] HALF_Q30    = 64'd536870912;

  localparam logic [63:0] K_10_67 = 64'd11453246123;
  localparam logic [63:0] K_32_0  = 64'd34359738368;
  localparam logic [63:0] K_38_4  = 64'd41231686042;
  localparam logic [63:0] K_2_8   = 64'd3006477107;
  localparam logic [63:0] K_5_33  = 64'd5726623061;
  localparam logic [63:0] K_6_4   = 64'd6871947674;
  localparam logic [63:0] K_9_6   = 64'd10307921510;
  localparam logic [63:0] K_21_33 = 64'd22906492245;
  localparam logic [63:0] K_48_0  = 64'd51539607552;
  localparam logic [63:0] K_0_067 = 64'd71582788;
  localparam logic [63:0] K_3_2   = 64'd3435973837;
  localparam logic [63:0] K_2_13  = 64'd2290649225;
  localparam logic [63:0] K_16_0  = 64'd17179869184;

endpackage
`default_nettype wire

// ===== hw/rtl/sga_arith_unit.sv =====
// Shared bit-serial multiply, divide and square root unit with saturation.
`default_nettype none
module sga_arith_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire sga_pkg::arith_req_t req,
  output logic                   done,
  output logic [63:0]            res,
  output logic [66:0]            prod
);
  import sga_pkg::*;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_SQRT,
    U_POST
  } ustate_t;

  ustate_t     state;
  op_t         op;
  logic        neg;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [63:0] hi;
  logic [63:0] lo;
  logic [5:0]  shift;
  logic [5:0]  cnt;
  logic [67:0] sq_rad;
  logic [35:0] sq_rem;
  logic [33:0] sq_root;

  logic [63:0]  mag_a;
  logic [63:0]  mag_b;
  logic [127:0] wide_start;
  logic [64:0]  mul_sum;
  logic [64:0]  div_t;
  logic         div_ge;
  logic [64:0]  div_diff;
  logic [127:0] prod_sh;
  logic [63:0]  mul_mag;
  logic [37:0]  sq_cur;
  logic [37:0]  sq_trial;
  logic         sq_ge;
  logic [37:0]  sq_diff;

  function automatic logic [63:0] sat_mag(input logic neg_in, input logic [63:0] mag_in);
    if (neg_in) begin
      return mag_in[63] ? 64'h8000_0000_0000_0000 : (64'd0 - mag_in);
    end
    return mag_in[63] ? 64'h7FFF_FFFF_FFFF_FFFF : mag_in;
  endfunction

  always_comb begin
    mag_a      = req.a[63] ? (64'd0 - req.a) : req.a;
    mag_b      = req.b[63] ? (64'd0 - req.b) : req.b;
    wide_start = {64'd0, mag_a} << req.shift;
    mul_sum    = {1'b0, hi} + (lo[0] ? {1'b0, ma} : 65'd0);
    div_t      = {hi, lo[63]};
    div_ge     = div_t >= {1'b0, mb};
    div_diff   = div_t - {1'b0, mb};
    prod_sh    = {hi, lo} >> shift;
    mul_mag    = (|prod_sh[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : prod_sh[63:0];
    sq_cur     = {sq_rem, sq_rad[67:66]};
    sq_trial   = {2'b00, sq_root, 2'b01};
    sq_ge      = sq_cur >= sq_trial;
    sq_diff    = sq_cur - sq_trial;
  end

  assign prod = {hi[2:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            op    <= req.op;
            neg   <= req.a[63] ^ req.b[63];
            ma    <= mag_a;
            mb    <= mag_b;
            shift <= req.shift;
            cnt   <= 6'd0;
            case (req.op)
              OP_MUL: begin
                hi    <= 64'd0;
                lo    <= mag_b;
                state <= U_MUL;
              end
              OP_DIV: begin
                if (mag_b == 64'd0) begin
                  res  <= (mag_a == 64'd0) ? 64'd0
                                           : sat_mag(req.a[63], 64'hFFFF_FFFF_FFFF_FFFF);
                  done <= 1'b1;
                end else if (wide_start[127:64] >= mag_b) begin
                  res  <= sat_mag(req.a[63] ^ req.b[63], 64'hFFFF_FFFF_FFFF_FFFF);
                  done <= 1'b1;
                end else begin
                  hi    <= wide_start[127:64];
                  lo    <= wide_start[63:0];
                  state <= U_DIV;
                end
              end
              OP_SQRT: begin
                sq_rad  <= req.rad;
                sq_rem  <= 36'd0;
                sq_root <= 34'd0;
                state   <= U_SQRT;
              end
              default: begin
                res  <= 64'd0;
                done <= 1'b1;
              end
            endcase
          end
        end
        U_MUL: begin
          hi  <= mul_sum[64:1];
          lo  <= {mul_sum[0], lo[63:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= U_POST;
          end
        end
        U_DIV: begin
          hi  <= div_ge ? div_diff[63:0] : div_t[63:0];
          lo  <= {lo[62:0], div_ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= U_POST;
          end
        end
        U_SQRT: begin
          if (sq_ge) begin
            sq_rem  <= sq_diff[35:0];
            sq_root <= {sq_root[32:0], 1'b1};
          end else begin
            sq_rem  <= sq_cur[35:0];
            sq_root <= {sq_root[32:0], 1'b0};
          end
          sq_rad <= {sq_rad[65:0], 2'b00};
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd33) begin
            state <= U_POST;
          end
        end
        U_POST: begin
          case (op)
            OP_MUL:  res <= sat_mag(neg, mul_mag);
            OP_DIV:  res <= sat_mag(neg, lo);
            OP_SQRT: res <= {30'd0, sq_root};
            default: res <= 64'd0;
          endcase
          done  <= 1'b1;
          state <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/softened_gravity_accumulator.sv =====
// Top level: interaction sequencer, running sums and stream ports.
// A zero-mass item skips the arithmetic; every other item runs a chain of
// operations on one shared bit-serial unit. The Newtonian chain is the shortest,
// the inner spline piece takes a longer one and the outer spline piece the
// longest of the three. One item is in work at a time.
// Reset clears the sums, count and handshakes and sets the softening length to 1.0.
`default_nettype none
module softened_gravity_accumulator #(
  parameter int POS_FRAC_BITS = 16,
  parameter int COUNT_WIDTH   = 24
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [30:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // target_x, target_y, target_z, source_x, source_y, source_z, source_mass
  input  wire logic [223:0] s_axis_tdata,
  // first_of_target
  input  wire logic         s_axis_tuser,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // accel_x, accel_y, accel_z, potential_sum, interaction_count
  output logic [((256+COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  import sga_pkg::*;

  localparam logic [5:0] SH_NEWT = 6'(POS_FRAC_BITS + 16);
  localparam logic [5:0] SH_PFB  = 6'(POS_FRAC_BITS);

  typedef enum logic [5:0] {
    ST_IDLE, ST_SQ, ST_ROOT,
    ST_NQ1, ST_NQ2, ST_NPOT, ST_NT, ST_NA,
    ST_SU, ST_SU2, ST_SU3,
    ST_IA, ST_IB, ST_IC, ST_ID, ST_IE,
    ST_OA, ST_OB, ST_OC, ST_OD, ST_OE, ST_OF, ST_OG, ST_OH, ST_OI,
    ST_MH, ST_SPOT, ST_FA, ST_FB, ST_SD, ST_SA,
    ST_ACCUM, ST_FINISH
  } seq_t;

  seq_t state;
  logic [30:0] soft_len;
  logic signed [32:0] dx, dy, dz;
  logic [31:0] mass;
  logic        last_item;
  logic [1:0]  k;
  logic        busy;
  logic [66:0] r2;
  logic [33:0] r;
  logic [63:0] u, u2, u3, kf, kp, mh, t0, t1;
  logic [63:0] acc_x, acc_y, acc_z, pot;
  logic [63:0] sum_x, sum_y, sum_z, sum_pot;
  logic [COUNT_WIDTH-1:0] count;
  logic [63:0] out_x, out_y, out_z, out_pot;
  logic [COUNT_WIDTH-1:0] out_count;
  logic        emit;

  arith_req_t  req;
  logic        start;
  logic        done;
  logic [63:0] res;
  logic [66:0] prod;

  logic [32:0] d_sel;
  logic [63:0] d64, r64, m64, h64, hp, r_sh;
  logic [63:0] root_sh;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

  sga_arith_unit u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .done  (done),
    .res   (res),
    .prod  (prod)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign emit          = (state == ST_FINISH) && last_item && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[255:0] = {out_pot, out_z, out_y, out_x};
    m_axis_tdata[256 +: COUNT_WIDTH] = out_count;
  end

  always_comb begin
    case (k)
      2'd0:    d_sel = dx;
      2'd1:    d_sel = dy;
      default: d_sel = dz;
    endcase
    d64     = {{31{d_sel[32]}}, d_sel};
    r64     = {30'd0, r};
    m64     = {32'd0, mass};
    h64     = {33'd0, soft_len};
    hp      = h64 << POS_FRAC_BITS;
    r_sh    = {14'd0, r, 16'd0};
    root_sh = {14'd0, res[33:0], 16'd0};
  end

  always_comb begin
    req.op    = OP_MUL;
    req.a     = 64'd0;
    req.b     = 64'd0;
    req.shift = Q_SHIFT;
    req.rad   = {1'b0, r2};
    case (state)
      ST_SQ:   begin req.a = d64; req.b = d64; req.shift = 6'd0; end
      ST_ROOT: req.op = OP_SQRT;
      ST_NQ1:  begin req.op = OP_DIV; req.a = m64; req.b = r64; req.shift = SH_NEWT; end
      ST_NQ2:  begin req.op = OP_DIV; req.a = t0; req.b = r64; req.shift = SH_PFB; end
      ST_NPOT: begin
        req.op = OP_DIV; req.a = 64'd0 - m64; req.b = r64; req.shift = SH_NEWT;
      end
      ST_NT:   begin req.op = OP_DIV; req.a = d64; req.b = r64; req.shift = DIR_SHIFT; end
      ST_NA:   begin req.a = t0; req.b = t1; req.shift = DIR_SHIFT; end
      ST_SU:   begin req.op = OP_DIV; req.a = r_sh; req.b = hp; end
      ST_SU2:  begin req.a = u; req.b = u; end
      ST_SU3:  begin req.a = u2; req.b = u; end
      ST_IA:   begin req.a = K_32_0; req.b = u; end
      ST_IB:   begin req.a = u2; req.b = t0 - K_38_4; end
      ST_IC:   begin req.a = K_6_4; req.b = u; end
      ST_ID:   begin req.a = u2; req.b = t0 - K_9_6; end
      ST_IE:   begin req.a = u2; req.b = K_5_33 + t0; end
      ST_OA:   begin req.a = K_48_0; req.b = u; end
      ST_OB:   begin req.a = K_38_4; req.b = u2; end
      ST_OC:   begin req.a = K_10_67; req.b = u3; end
      ST_OD:   begin req.op = OP_DIV; req.a = K_0_067; req.b = u3; end
      ST_OE:   begin req.op = OP_DIV; req.a = K_0_067; req.b = u; end
      ST_OF:   begin req.a = K_2_13; req.b = u; end
      ST_OG:   begin req.a = u; req.b = K_9_6 - t0; end
      ST_OH:   begin req.a = u; req.b = t0 - K_16_0; end
      ST_OI:   begin req.a = u2; req.b = K_10_67 + t0; end
      ST_MH:   begin req.op = OP_DIV; req.a = m64; req.b = h64; req.shift = MH_SHIFT; end
      ST_SPOT: begin req.a = mh; req.b = kp; end
      ST_FA:   begin req.op = OP_DIV; req.a = mh; req.b = h64; req.shift = MHH_SHIFT; end
      ST_FB:   begin req.a = t0; req.b = kf; end
      ST_SD:   begin req.op = OP_DIV; req.a = d64 << 16; req.b = hp; end
      ST_SA:   begin req.a = t0; req.b = t1; end
      default: req.op = OP_MUL;
    endcase
  end

  assign start = !busy && (state != ST_IDLE) && (state != ST_ACCUM) && (state != ST_FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      soft_len      <= SOFT_RESET;
      busy          <= 1'b0;
      sum_x         <= 64'd0;
      sum_y         <= 64'd0;
      sum_z         <= 64'd0;
      sum_pot       <= 64'd0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        soft_len <= cfg_data;
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (start) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            dx        <= 33'($signed(s_axis_tdata[127:96])) - 33'($signed(s_axis_tdata[31:0]));
            dy        <= 33'($signed(s_axis_tdata[159:128])) - 33'($signed(s_axis_tdata[63:32]));
            dz        <= 33'($signed(s_axis_tdata[191:160])) - 33'($signed(s_axis_tdata[95:64]));
            mass      <= s_axis_tdata[223:192];
            last_item <= s_axis_tlast;
            k         <= 2'd0;
            acc_x     <= 64'd0;
            acc_y     <= 64'd0;
            acc_z     <= 64'd0;
            pot       <= 64'd0;
            if (s_axis_tuser) begin
              sum_x   <= 64'd0;
              sum_y   <= 64'd0;
              sum_z   <= 64'd0;
              sum_pot <= 64'd0;
              count   <= '0;
            end
            state <= (s_axis_tdata[223:192] == 32'd0) ? ST_FINISH : ST_SQ;
          end
        end
        ST_ACCUM: begin
          sum_x   <= sat_add(sum_x, acc_x);
          sum_y   <= sat_add(sum_y, acc_y);
          sum_z   <= sat_add(sum_z, acc_z);
          sum_pot <= sat_add(sum_pot, pot);
          if (count != {COUNT_WIDTH{1'b1}}) begin
            count <= count + COUNT_WIDTH'(1);
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!last_item) begin
            state <= ST_IDLE;
          end else if (emit) begin
            out_x     <= sum_x;
            out_y     <= sum_y;
            out_z     <= sum_z;
            out_pot   <= sum_pot;
            out_count <= count;
            state     <= ST_IDLE;
          end
        end
        default: begin
          if (done) begin
            case (state)
              ST_SQ: begin
                r2 <= ((k == 2'd0) ? 67'd0 : r2) + prod;
                if (k == 2'd2) begin
                  k     <= 2'd0;
                  state <= ST_ROOT;
                end else begin
                  k <= k + 2'd1;
                end
              end
              ST_ROOT: begin
                r <= res[33:0];
                if (root_sh >= hp) begin
                  state <= (res[33:0] == 34'd0) ? ST_ACCUM : ST_NQ1;
                end else begin
                  state <= ST_SU;
                end
              end
              ST_NQ1:  begin t0 <= res; state <= ST_NQ2; end
              ST_NQ2:  begin t0 <= res; state <= ST_NPOT; end
              ST_NPOT: begin pot <= res; state <= ST_NT; end
              ST_NT:   begin t1 <= res; state <= ST_NA; end
              ST_SU:   begin u <= res; state <= ST_SU2; end
              ST_SU2:  begin u2 <= res; state <= ST_SU3; end
              ST_SU3: begin
                u3    <= res;
                state <= ($signed(u) < $signed(HALF_Q30)) ? ST_IA : ST_OA;
              end
              ST_IA:   begin t0 <= res; state <= ST_IB; end
              ST_IB:   begin kf <= K_10_67 + res; state <= ST_IC; end
              ST_IC:   begin t0 <= res; state <= ST_ID; end
              ST_ID:   begin t0 <= res; state <= ST_IE; end
              ST_IE:   begin kp <= res - K_2_8; state <= ST_MH; end
              ST_OA:   begin kf <= K_21_33 - res; state <= ST_OB; end
              ST_OB:   begin kf <= kf + res; state <= ST_OC; end
              ST_OC:   begin kf <= kf - res; state <= ST_OD; end
              ST_OD:   begin kf <= kf - res; state <= ST_OE; end
              ST_OE:   begin kp <= res - K_3_2; state <= ST_OF; end
              ST_OF:   begin t0 <= res; state <= ST_OG; end
              ST_OG:   begin t0 <= res; state <= ST_OH; end
              ST_OH:   begin t0 <= res; state <= ST_OI; end
              ST_OI:   begin kp <= kp + res; state <= ST_MH; end
              ST_MH:   begin mh <= res; state <= ST_SPOT; end
              ST_SPOT: begin pot <= res; state <= ST_FA; end
              ST_FA:   begin t0 <= res; state <= ST_FB; end
              ST_FB:   begin t0 <= res; state <= ST_SD; end
              ST_SD:   begin t1 <= res; state <= ST_SA; end
              ST_NA, ST_SA: begin
                case (k)
                  2'd0:    acc_x <= res;
                  2'd1:    acc_y <= res;
                  default: acc_z <= res;
                endcase
                if (k == 2'd2) begin
                  state <= ST_ACCUM;
                end else begin
                  k     <= k + 2'd1;
                  state <= (state == ST_NA) ? ST_NT : ST_SD;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire
